/* rtl/core/pid_position_loop_with_dwell_defines.svh */
// Assertion macros for the position loop, clocked on clk, disabled in reset.
`ifndef PID_POSITION_LOOP_WITH_DWELL_DEFINES_SVH
`define PID_POSITION_LOOP_WITH_DWELL_DEFINES_SVH

// Same-cycle implication.
`define PPLD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PPLD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ppld_pkg.sv */
// Constants and register codes for the position loop with dwell detection.
package ppld_pkg;

	localparam int ANGLE_WIDTH_DEF    = 16;
	localparam int GAIN_FRAC_BITS_DEF = 12;

	localparam int ANGLE_FRAC = 12;
	localparam int DRIVE_FRAC = 14;
	localparam int DRIVE_W    = 16;
	localparam int DRIVE_ONE  = 16384;

	localparam int GAIN_W  = 20;
	localparam int LIMIT_W = 19;
	localparam int SUM_W   = LIMIT_W + 1;
	localparam int TOL_W   = 15;
	localparam int DWELL_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [GAIN_W-1:0]  KP_RESET    = GAIN_W'(16384);
	localparam logic [GAIN_W-1:0]  KI_RESET    = GAIN_W'(123);
	localparam logic [GAIN_W-1:0]  KD_RESET    = GAIN_W'(81920);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(61440);
	localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(143);
	localparam logic [DWELL_W-1:0] DWELL_RESET = DWELL_W'(40);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP    = 3'd0,
		REG_KI    = 3'd1,
		REG_KD_DT = 3'd2,
		REG_LIMIT = 3'd3,
		REG_TOL   = 3'd4,
		REG_DWELL = 3'd5
	} cfg_reg_t;

endpackage

/* rtl/core/pid_position_loop_with_dwell.sv */
// Position loop top level: saturated error, PID drive, integral clamp, dwell detect.
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid in_ready start_move setpoint target   | in
//          | measured                                       |
//  out     | out_valid out_ready drive_power drive_valid    | out
//          | in_position angle_error                        |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data         | in
//
//  One beat per cycle sustained while out_ready is high; a beat passes the input register, then the result register.
//  The input register feeds three parallel gain multipliers and the adder/clip path
//  into the result register; loop state updates as the result is loaded unless the loop holds.
//  Reset: configuration registers at defaults, loop state cleared, holding set.
//  An input beat is taken while a result waits as long as the input register is free.
//  cfg_ready is always high.
`include "pid_position_loop_with_dwell_defines.svh"

module pid_position_loop_with_dwell #(
	parameter int ANGLE_WIDTH    = ppld_pkg::ANGLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = ppld_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  start_move,
	input  logic signed [ANGLE_WIDTH-1:0]         setpoint,
	input  logic signed [ANGLE_WIDTH-1:0]         target,
	input  logic signed [ANGLE_WIDTH-1:0]         measured,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ppld_pkg::DRIVE_W-1:0]   drive_power,
	output logic                                  drive_valid,
	output logic                                  in_position,
	output logic signed [ANGLE_WIDTH-1:0]         angle_error,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ppld_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ppld_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int AW      = ANGLE_WIDTH;
	localparam int GW      = ppld_pkg::GAIN_W;
	localparam int SW      = ppld_pkg::SUM_W;
	localparam int DW      = ppld_pkg::DWELL_W;
	localparam int SHIFT   = ppld_pkg::ANGLE_FRAC + GAIN_FRAC_BITS - ppld_pkg::DRIVE_FRAC;
	localparam int KP_PW   = GW + AW + 1;
	localparam int KD_PW   = GW + AW + 2;
	localparam int KI_PW   = GW + SW + 1;
	localparam int MAXP_W  = (KD_PW > KI_PW) ? KD_PW : KI_PW;
	localparam int ACC_W   = MAXP_W + 2;
	localparam int MAG_W   = (AW > ppld_pkg::TOL_W) ? AW : ppld_pkg::TOL_W;
	localparam int NS_W    = ((SW > AW) ? SW : AW) + 1;

	localparam logic signed [ACC_W-1:0] ONE_P = ACC_W'(ppld_pkg::DRIVE_ONE);
	localparam logic signed [ACC_W-1:0] ONE_N = -ACC_W'(ppld_pkg::DRIVE_ONE);
	localparam logic signed [AW-1:0]    AMAX  = {1'b0, {(AW-1){1'b1}}};
	localparam logic signed [AW-1:0]    AMIN  = {1'b1, {(AW-1){1'b0}}};

	// configuration registers
	logic [GW-1:0]                   kp_q, ki_q, kd_q;
	logic [ppld_pkg::LIMIT_W-1:0]    limit_q;
	logic [ppld_pkg::TOL_W-1:0]      tol_q;
	logic [DW-1:0]                   dwell_ticks_q;

	// loop state
	logic signed [AW-1:0] prev_q;
	logic signed [SW-1:0] sum_q;
	logic [DW-1:0]        dwell_q;
	logic                 hold_q;

	// input register
	logic                 valid_s1;
	logic                 start_s1;
	logic signed [AW-1:0] sp_s1, tg_s1, ms_s1;

	// result register
	logic                                 out_valid_q;
	logic signed [ppld_pkg::DRIVE_W-1:0]  drive_q;
	logic                                 drive_valid_q;
	logic                                 in_pos_q;
	logic signed [AW-1:0]                 err_q;

	logic adv;

	// datapath
	logic signed [AW:0]        err_raw;
	logic signed [AW-1:0]      err_sat;
	logic signed [AW-1:0]      prev_eff;
	logic signed [SW-1:0]      sum_eff;
	logic [DW-1:0]             dwell_eff;
	logic                      hold_eff;
	logic signed [AW:0]        diff;
	logic signed [GW:0]        kp_s, ki_s, kd_s;
	logic signed [KP_PW-1:0]   p_kp;
	logic signed [KD_PW-1:0]   p_kd;
	logic signed [KI_PW-1:0]   p_ki;
	logic signed [ACC_W-1:0]   acc, acc_sh;
	logic signed [ppld_pkg::DRIVE_W-1:0] drive_clip, drive_nxt;
	logic signed [AW:0]        err_ext, mag_ext;
	logic [AW-1:0]             mag_abs;
	logic                      on_target, dwell_done;
	logic signed [NS_W-1:0]    ns, lim_p, lim_n, ns_clamp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q          <= ppld_pkg::KP_RESET;
			ki_q          <= ppld_pkg::KI_RESET;
			kd_q          <= ppld_pkg::KD_RESET;
			limit_q       <= ppld_pkg::LIMIT_RESET;
			tol_q         <= ppld_pkg::TOL_RESET;
			dwell_ticks_q <= ppld_pkg::DWELL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				ppld_pkg::REG_KP:    kp_q          <= cfg_data[GW-1:0];
				ppld_pkg::REG_KI:    ki_q          <= cfg_data[GW-1:0];
				ppld_pkg::REG_KD_DT: kd_q          <= cfg_data[GW-1:0];
				ppld_pkg::REG_LIMIT: limit_q       <= cfg_data[ppld_pkg::LIMIT_W-1:0];
				ppld_pkg::REG_TOL:   tol_q         <= cfg_data[ppld_pkg::TOL_W-1:0];
				ppld_pkg::REG_DWELL: dwell_ticks_q <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			start_s1 <= start_move;
			sp_s1    <= setpoint;
			tg_s1    <= target;
			ms_s1    <= measured;
		end
	end

	// saturated error
	assign err_raw = (AW+1)'(sp_s1) - (AW+1)'(ms_s1);
	always_comb begin
		if (err_raw[AW] != err_raw[AW-1]) begin
			err_sat = err_raw[AW] ? AMIN : AMAX;
		end else begin
			err_sat = err_raw[AW-1:0];
		end
	end

	// start clears the loop state before tracking
	assign prev_eff  = start_s1 ? '0 : prev_q;
	assign sum_eff   = start_s1 ? '0 : sum_q;
	assign dwell_eff = start_s1 ? '0 : dwell_q;
	assign hold_eff  = start_s1 ? 1'b0 : hold_q;

	assign diff = (AW+1)'(err_sat) - (AW+1)'(prev_eff);
	assign kp_s = $signed({1'b0, kp_q});
	assign ki_s = $signed({1'b0, ki_q});
	assign kd_s = $signed({1'b0, kd_q});
	assign p_kp = kp_s * err_sat;
	assign p_kd = kd_s * diff;
	assign p_ki = ki_s * sum_eff;
	assign acc    = ACC_W'(p_kp) + ACC_W'(p_kd) + ACC_W'(p_ki);
	assign acc_sh = acc >>> SHIFT;

	always_comb begin
		if (acc_sh > ONE_P) begin
			drive_clip = ppld_pkg::DRIVE_W'(ppld_pkg::DRIVE_ONE);
		end else if (acc_sh < ONE_N) begin
			drive_clip = -ppld_pkg::DRIVE_W'(ppld_pkg::DRIVE_ONE);
		end else begin
			drive_clip = acc_sh[ppld_pkg::DRIVE_W-1:0];
		end
	end

	// dwell detect
	assign err_ext    = (AW+1)'(err_sat);
	assign mag_ext    = err_ext[AW] ? -err_ext : err_ext;
	assign mag_abs    = mag_ext[AW-1:0];
	assign on_target  = (MAG_W'(mag_abs) < MAG_W'(tol_q)) && (sp_s1 == tg_s1);
	assign dwell_done = on_target && (dwell_eff >= dwell_ticks_q);
	assign drive_nxt  = (hold_eff || dwell_done) ? '0 : drive_clip;

	// integral update with clamp
	assign ns    = NS_W'(sum_eff) + NS_W'(err_sat);
	assign lim_p = NS_W'({1'b0, limit_q});
	assign lim_n = -lim_p;
	always_comb begin
		if (ns > lim_p) begin
			ns_clamp = lim_p;
		end else if (ns < lim_n) begin
			ns_clamp = lim_n;
		end else begin
			ns_clamp = ns;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			sum_q   <= '0;
			dwell_q <= '0;
			hold_q  <= 1'b1;
		end else if (adv && !hold_eff) begin
			prev_q  <= err_sat;
			sum_q   <= ns_clamp[SW-1:0];
			dwell_q <= !on_target ? '0 : (dwell_done ? dwell_eff : dwell_eff + 1'b1);
			hold_q  <= dwell_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_q       <= drive_nxt;
			drive_valid_q <= !hold_eff;
			in_pos_q      <= hold_eff || dwell_done;
			err_q         <= err_sat;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_power = drive_q;
	assign drive_valid = drive_valid_q;
	assign in_position = in_pos_q;
	assign angle_error = err_q;

	`PPLD_ASSERT_NOW(a_drive_range, out_valid,
		(drive_power <= 16'sd16384) && (drive_power >= -16'sd16384), "drive out of range")
	`PPLD_ASSERT_NOW(a_hold_no_drive, out_valid && !drive_valid,
		(drive_power == '0) && in_position, "drive issued while holding")
	`PPLD_ASSERT_NOW(a_arrive_zero, out_valid && drive_valid && in_position,
		drive_power == '0, "nonzero drive on arrival")
	`PPLD_ASSERT_NEXT(a_hold_frozen, adv && hold_q && !start_s1,
		$stable(sum_q) && $stable(prev_q) && $stable(dwell_q) && hold_q,
		"loop state changed while holding")
	`PPLD_ASSERT_NEXT(a_result_loaded, adv, out_valid, "accepted beat produced no result")

endmodule

/* sim/pid_position_loop_with_dwell_test.sv */
// Testbench for the position loop: PID drive, integral clamp and dwell checked beat by beat.
`timescale 1ns / 100ps

module pid_position_loop_with_dwell_test;
	import ppld_pkg::*;

	localparam int AW          = ANGLE_WIDTH_DEF;
	localparam int DRIVE_SHIFT = ANGLE_FRAC + GAIN_FRAC_BITS_DEF - DRIVE_FRAC;
	localparam int SETTLE      = 6;
	localparam int LIMIT_CYCLES = 300000;
	localparam int PHASE_ITEMS = 80;
	localparam longint AMAX = (longint'(1) << (AW - 1)) - 1;
	localparam longint AMIN = -AMAX - 1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
	localparam logic [CFG_DATA_W-1:0] DATA_MAX = '1;

	typedef struct {
		logic                 start;
		logic signed [AW-1:0] sp;
		logic signed [AW-1:0] tg;
		logic signed [AW-1:0] ms;
	} tick_cmd_t;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		logic                      dvalid;
		logic                      inpos;
		logic signed [AW-1:0]      aerr;
	} tick_out_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic start_move = 0;
	logic signed [AW-1:0] setpoint = '0;
	logic signed [AW-1:0] target = '0;
	logic signed [AW-1:0] measured = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [DRIVE_W-1:0] drive_power;
	logic drive_valid;
	logic in_position;
	logic signed [AW-1:0] angle_error;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of registers and loop state
	logic [GAIN_W-1:0]  gain_p, gain_i, gain_d;
	logic [LIMIT_W-1:0] sum_limit;
	logic [TOL_W-1:0]   on_target_tol;
	logic [DWELL_W-1:0] dwell_need;
	logic signed [AW-1:0]    last_err;
	logic signed [SUM_W-1:0] err_acc;
	logic [DWELL_W-1:0]      dwell_run;
	logic                    parked;

	tick_out_t expected_ticks[$];
	int mismatch_count = 0;
	int items_sent = 0;
	bit steady = 0;

	pid_position_loop_with_dwell uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.start_move  (start_move),
		.setpoint    (setpoint),
		.target      (target),
		.measured    (measured),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive_power (drive_power),
		.drive_valid (drive_valid),
		.in_position (in_position),
		.angle_error (angle_error),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic signed [AW-1:0] sat_angle(longint v);
		if (v > AMAX) v = AMAX;
		if (v < AMIN) v = AMIN;
		return AW'(v);
	endfunction

	function automatic logic signed [AW-1:0] rand_angle();
		return AW'($urandom);
	endfunction

	function automatic void load_defaults();
		gain_p        = KP_RESET;
		gain_i        = KI_RESET;
		gain_d        = KD_RESET;
		sum_limit     = LIMIT_RESET;
		on_target_tol = TOL_RESET;
		dwell_need    = DWELL_RESET;
		last_err      = '0;
		err_acc       = '0;
		dwell_run     = '0;
		parked        = 1'b1;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_KP:    gain_p        = data[GAIN_W-1:0];
			REG_KI:    gain_i        = data[GAIN_W-1:0];
			REG_KD_DT: gain_d        = data[GAIN_W-1:0];
			REG_LIMIT: sum_limit     = data[LIMIT_W-1:0];
			REG_TOL:   on_target_tol = data[TOL_W-1:0];
			REG_DWELL: dwell_need    = data[DWELL_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic tick_out_t loop_tick(tick_cmd_t c);
		longint e, acc, d, ns, mag, lim;
		tick_out_t r;
		e = longint'(c.sp) - longint'(c.ms);
		if (e > AMAX) e = AMAX;
		if (e < AMIN) e = AMIN;
		if (c.start) begin
			last_err  = '0;
			err_acc   = '0;
			dwell_run = '0;
			parked    = 1'b0;
		end
		d = 0;
		r.dvalid = 1'b0;
		if (!parked) begin
			acc = longint'(gain_p) * e
				+ longint'(gain_d) * (e - longint'(last_err))
				+ longint'(gain_i) * longint'(err_acc);
			d = acc >>> DRIVE_SHIFT;
			if (d > DRIVE_ONE) d = DRIVE_ONE;
			if (d < -DRIVE_ONE) d = -DRIVE_ONE;
			last_err = AW'(e);
			lim = longint'(sum_limit);
			ns = longint'(err_acc) + e;
			if (ns > lim) ns = lim;
			if (ns < -lim) ns = -lim;
			err_acc = SUM_W'(ns);
			mag = (e < 0) ? -e : e;
			if (mag < longint'(on_target_tol) && c.sp == c.tg) begin
				if (dwell_run >= dwell_need) begin
					d = 0;
					parked = 1'b1;
				end else begin
					dwell_run = dwell_run + 1'b1;
				end
			end else begin
				dwell_run = '0;
			end
			r.dvalid = 1'b1;
		end
		r.drive = DRIVE_W'(d);
		r.inpos = parked;
		r.aerr  = AW'(e);
		return r;
	endfunction

	task automatic compare_field(string name, longint want, longint got, bit bad);
		if (bad) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// beat monitor: register writes, result checks, expectations
	always @(posedge clk) begin
		tick_out_t want;
		tick_cmd_t cmd;
		if (!arst_n) begin
			load_defaults();
		end else begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (out_valid && out_ready) begin
				if (expected_ticks.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual drive_power %0d",
						$time, drive_power);
					mismatch_count++;
				end else begin
					want = expected_ticks.pop_front();
					compare_field("drive_power", want.drive, drive_power,
						drive_power !== want.drive);
					compare_field("drive_valid", want.dvalid, drive_valid,
						drive_valid !== want.dvalid);
					compare_field("in_position", want.inpos, in_position,
						in_position !== want.inpos);
					compare_field("angle_error", want.aerr, angle_error,
						angle_error !== want.aerr);
				end
			end
			if (in_valid && in_ready) begin
				cmd.start = start_move;
				cmd.sp    = setpoint;
				cmd.tg    = target;
				cmd.ms    = measured;
				expected_ticks.push_back(loop_tick(cmd));
			end
		end
	end

	// result side: random stall before each beat unless steady is set
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_tick(logic st, logic signed [AW-1:0] sp, logic signed [AW-1:0] tg,
			logic signed [AW-1:0] ms);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		start_move <= st;
		setpoint   <= sp;
		target     <= tg;
		measured   <= ms;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_ticks.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_all(logic [CFG_DATA_W-1:0] kp, logic [CFG_DATA_W-1:0] ki,
			logic [CFG_DATA_W-1:0] kd, logic [CFG_DATA_W-1:0] lim,
			logic [CFG_DATA_W-1:0] tol, logic [CFG_DATA_W-1:0] dw);
		wait_idle();
		cfg_write(REG_KP, kp);
		cfg_write(REG_KI, ki);
		cfg_write(REG_KD_DT, kd);
		cfg_write(REG_LIMIT, lim);
		cfg_write(REG_TOL, tol);
		cfg_write(REG_DWELL, dw);
	endtask

	// out of reset the loop is parked: no drive until a move starts
	task automatic test_parked_after_reset();
		send_tick(1'b0, rand_angle(), rand_angle(), sat_angle(AMIN));
		send_tick(1'b0, sat_angle(AMAX), rand_angle(), sat_angle(AMAX));
		send_tick(1'b0, sat_angle(AMIN), sat_angle(AMIN), rand_angle());
	endtask

	task automatic test_error_saturation();
		cfg_all(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, 0);
		send_tick(1'b1, sat_angle(AMAX), sat_angle(0), sat_angle(AMIN));
		send_tick(1'b0, sat_angle(AMIN), sat_angle(0), sat_angle(AMAX));
		send_tick(1'b0, sat_angle(0), sat_angle(AMAX), sat_angle(0));
		send_tick(1'b1, sat_angle(AMIN), sat_angle(AMAX), sat_angle(AMAX));
		send_tick(1'b0, sat_angle(-1), sat_angle(AMIN), sat_angle(0));
	endtask

	task automatic test_integral_clamp();
		cfg_all(0, DATA_MAX, 0, 0, 0, 0);
		send_tick(1'b1, sat_angle(1000), sat_angle(0), sat_angle(0));
		send_tick(1'b0, sat_angle(1000), sat_angle(0), sat_angle(0));
		cfg_all(0, DATA_MAX, 0, 100, 0, 0);
		send_tick(1'b1, sat_angle(-3000), sat_angle(0), sat_angle(0));
		send_tick(1'b0, sat_angle(-3000), sat_angle(0), sat_angle(0));
		send_tick(1'b0, sat_angle(2000), sat_angle(0), sat_angle(0));
	endtask

	task automatic test_dwell();
		// widest tolerance, no dwell: parks on the first on-target tick
		cfg_all(KP_RESET, KI_RESET, KD_RESET, LIMIT_RESET, 32767, 0);
		send_tick(1'b1, sat_angle(500), sat_angle(500), sat_angle(-20000));
		send_tick(1'b0, sat_angle(7), sat_angle(9), sat_angle(7));
		// zero tolerance never counts as on target
		cfg_all(KP_RESET, KI_RESET, KD_RESET, LIMIT_RESET, 0, 0);
		send_tick(1'b1, sat_angle(500), sat_angle(500), sat_angle(500));
		send_tick(1'b0, sat_angle(500), sat_angle(500), sat_angle(500));
		cfg_all(KP_RESET, KI_RESET, KD_RESET, LIMIT_RESET, 500, 2);
		send_tick(1'b1, sat_angle(1000), sat_angle(1000), sat_angle(1000));
		send_tick(1'b0, sat_angle(1000), sat_angle(1000), sat_angle(1499));
		send_tick(1'b0, sat_angle(1000), sat_angle(1000), sat_angle(501));
		send_tick(1'b0, sat_angle(1000), sat_angle(1000), sat_angle(1000));
		send_tick(1'b0, sat_angle(1000), sat_angle(1000), sat_angle(1000));
		send_tick(1'b1, sat_angle(1000), sat_angle(1000), sat_angle(500));
	endtask

	// one move: ramp toward target, then settle inside the tolerance
	task automatic run_move();
		longint tgt, origin, sp, ms;
		int ramp, tail, extra, span, n;
		logic st;
		tgt    = longint'(rand_angle());
		origin = longint'(sat_angle(tgt + longint'($urandom_range(0, 16000)) - 8000));
		ramp   = $urandom_range(0, 8);
		tail   = (dwell_need > 40) ? $urandom_range(4, 12)
			: int'(dwell_need) + $urandom_range(1, 6);
		extra  = $urandom_range(0, 3);
		steady = ($urandom_range(0, 3) == 0);
		for (n = 0; n < ramp + tail + extra; n++) begin
			sp   = (n >= ramp) ? tgt : origin + (tgt - origin) * n / ramp;
			span = (n < ramp) ? 600 : int'(on_target_tol) / 2 + 1;
			ms   = sp + longint'($urandom_range(0, 2 * span)) - span;
			if ($urandom_range(0, 15) == 0)
				ms = longint'(rand_angle());
			st = (n == 0) || ($urandom_range(0, 31) == 0);
			send_tick(st, sat_angle(sp), sat_angle(tgt), sat_angle(ms));
		end
	endtask

	task automatic run_noise();
		int n;
		steady = ($urandom_range(0, 3) == 0);
		for (n = 0; n < $urandom_range(1, 4); n++)
			send_tick($urandom_range(0, 7) == 0, rand_angle(), rand_angle(), rand_angle());
	endtask

	task automatic test_random_moves();
		int phase, stop;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: cfg_all(KP_RESET, KI_RESET, KD_RESET, LIMIT_RESET, TOL_RESET, DWELL_RESET);
				1: cfg_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				2: cfg_all(0, 0, 0, DATA_MAX, DATA_MAX, DATA_MAX);
				3: cfg_all(DATA_MAX, DATA_MAX, DATA_MAX, 0, $urandom_range(0, 3000), 0);
				default: begin
					cfg_all($urandom_range(0, 65535), $urandom_range(0, 4095),
						$urandom_range(0, 262143), $urandom, $urandom_range(100, 2000),
						$urandom_range(0, 15));
					cfg_write(REG_SPARE_A, $urandom);
					cfg_write(REG_SPARE_B, $urandom);
				end
			endcase
			stop = items_sent + PHASE_ITEMS;
			while (items_sent < stop) begin
				if ($urandom_range(0, 4) == 0)
					run_noise();
				else
					run_move();
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_parked_after_reset();
		test_error_saturation();
		test_integral_clamp();
		test_dwell();
		test_random_moves();
		wait_idle();
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ppld_pkg.sv
rtl/core/pid_position_loop_with_dwell.sv
sim/pid_position_loop_with_dwell_test.sv
